/* rtl/chip8_interpreter_core_defines.svh */
// assertion macros shared by the interpreter core rtl
// each macro samples on clk and is held off while arst_n is low
`ifndef CHIP8_INTERPRETER_CORE_DEFINES_SVH
`define CHIP8_INTERPRETER_CORE_DEFINES_SVH

// same-cycle implication
`define C8I_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define C8I_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/c8i_pkg.sv */
// ----------------------------------------------------------------------------
// c8i_pkg
// shared types, codes and tables of the chip8 interpreter core
// ----------------------------------------------------------------------------
`default_nettype none

package c8i_pkg;

	localparam int unsigned SCREEN_COLS  = 64;
	localparam int unsigned SCREEN_ROWS  = 32;
	localparam int unsigned PROGRAM_BASE = 512;
	localparam int unsigned FONT_BASE    = 0;
	localparam int unsigned FONT_BYTES   = 80;

	localparam logic [1:0] MODE_EXEC = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_LOAD = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_OR,
		ALU_AND,
		ALU_XOR,
		ALU_SHR,
		ALU_SHL,
		ALU_PASS
	} alu_op_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] key_mask;
		logic [7:0]  random_byte;
		logic [11:0] load_address;
		logic [7:0]  load_data;
		logic [4:0]  row_select;
	} cmd_word_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [15:0] fetched_opcode;
		logic        draw_flag;
		logic        unknown_opcode;
		logic        waiting_key;
		logic        sound_on;
		logic [63:0] row_pixels;
	} rsp_word_t;

	localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	function automatic logic [7:0] glyph(input logic [6:0] idx);
		return GLYPHS[idx];
	endfunction

	// decimal digit k of v: 0 hundreds, 1 tens, 2 ones
	function automatic logic [3:0] bcd_digit(input logic [7:0] v, input logic [1:0] k);
		logic [7:0] r;
		logic [3:0] h;
		logic [3:0] t;
		logic [7:0] o;
		if (v >= 8'd200) begin
			h = 4'd2;
			r = v - 8'd200;
		end else if (v >= 8'd100) begin
			h = 4'd1;
			r = v - 8'd100;
		end else begin
			h = 4'd0;
			r = v;
		end
		t = 4'd0;
		for (int d = 9; d >= 1; d--) begin
			if (t == 4'd0 && r >= 8'(d * 10))
				t = 4'(d);
		end
		o = r - 8'(t * 10);
		if (k == 2'd0)
			return h;
		else if (k == 2'd1)
			return t;
		else
			return o[3:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/c8i_stream_if.sv */
// ----------------------------------------------------------------------------
// c8i_stream_if
// valid/ready channel carrying one word per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface c8i_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/c8i_alu.sv */
// ----------------------------------------------------------------------------
// c8i_alu
// shared 12-bit arithmetic and logic unit with carry/borrow in bit 12
// ----------------------------------------------------------------------------
`default_nettype none

module c8i_alu (
	input  c8i_pkg::alu_op_t op,
	input  logic [11:0]      a,
	input  logic [11:0]      b,
	output logic [12:0]      y
);

	always_comb begin
		unique case (op)
			c8i_pkg::ALU_ADD:  y = {1'b0, a} + {1'b0, b};
			c8i_pkg::ALU_SUB:  y = {1'b0, a} - {1'b0, b};
			c8i_pkg::ALU_OR:   y = {1'b0, a | b};
			c8i_pkg::ALU_AND:  y = {1'b0, a & b};
			c8i_pkg::ALU_XOR:  y = {1'b0, a ^ b};
			c8i_pkg::ALU_SHR:  y = {2'b00, a[11:1]};
			c8i_pkg::ALU_SHL:  y = {a, 1'b0};
			c8i_pkg::ALU_PASS: y = {1'b0, b};
		endcase
	end

endmodule

`default_nettype wire

/* rtl/c8i_ram.sv */
// ----------------------------------------------------------------------------
// c8i_ram
// byte memory with one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module c8i_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/chip8_interpreter_core.sv */
// ----------------------------------------------------------------------------
// chip8_interpreter_core
// chip8 machine with program memory, display, registers, stack and timers
// ----------------------------------------------------------------------------
// cmd channel: one word per item; mode selects execute, timer tick, memory
// byte load or display row read. rsp channel: exactly one word per item.
// after reset the program memory is swept once, one byte a cycle, writing
// the font and zeros: cmd.ready stays low until the sweep ends.
// one item at a time, driven by a small sequencer around a single alu and
// one memory with one write port and one read port:
//   tick, load, read: a misc step, then the result step
//   execute: fetch takes two memory reads, vx and vy are read in two more
//   steps, then an execute step and, but for jumps, calls and a key wait,
//   a pc update step; a return adds a stack read step
//   sprite draw adds a memory read then an xor per sprite row, bcd store
//   three digit writes, register block store a write per register, and
//   block load, the longest item, a read then a write per register.
// the result sits in an output register; the next item may be accepted
// while it waits, but that item holds in its last step until rsp is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chip8_interpreter_core_defines.svh"

module chip8_interpreter_core #(
	parameter int MEMORY_BYTES = 4096,
	parameter int STACK_DEPTH  = 16
) (
	input  logic clk,
	input  logic arst_n,
	c8i_stream_if.sink   cmd,
	c8i_stream_if.source rsp
);

	localparam int AW = $clog2(MEMORY_BYTES);
	localparam int SW = $clog2(STACK_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE,
		S_MISC,
		S_FETCH_HI,
		S_FETCH_LO,
		S_OPCODE,
		S_READ_X,
		S_READ_Y,
		S_EXEC,
		S_RET,
		S_DRAW_RD,
		S_DRAW_XOR,
		S_DRAW_END,
		S_BCD,
		S_STORE,
		S_LOAD_RD,
		S_LOAD_WR,
		S_ADVANCE,
		S_DONE
	} state_t;

	state_t state_q;

	// architectural state
	logic [11:0] pc_q;
	logic [11:0] i_q;
	logic [7:0]  v_q [16];
	logic [11:0] stack_q [STACK_DEPTH];
	logic [SW-1:0] sp_q;
	logic [7:0]  delay_q;
	logic [7:0]  sound_q;
	logic [63:0] disp_q [c8i_pkg::SCREEN_ROWS];

	// memory clearing pass
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// per item
	logic [1:0]  mode_q;
	logic [15:0] keys_q;
	logic [7:0]  rnd_q;
	logic [11:0] laddr_q;
	logic [7:0]  ldata_q;
	logic [4:0]  row_sel_q;
	logic [15:0] op_q;
	logic [7:0]  vx_q;
	logic [7:0]  vy_q;
	logic [3:0]  cnt_q;
	logic [2:0]  step_q;
	logic        coll_q;
	logic        drew_q;
	logic        unk_q;
	logic        wait_q;

	logic        rsp_valid_q;
	c8i_pkg::rsp_word_t rsp_data_q;

	// decode fields
	logic [3:0]  op_hi;
	logic [3:0]  op_x;
	logic [3:0]  op_y;
	logic [3:0]  op_n;
	logic [7:0]  op_nn;
	logic [11:0] op_nnn;

	assign op_hi  = op_q[15:12];
	assign op_x   = op_q[11:8];
	assign op_y   = op_q[7:4];
	assign op_n   = op_q[3:0];
	assign op_nn  = op_q[7:0];
	assign op_nnn = op_q[11:0];

	function automatic logic [AW-1:0] mem_addr(input logic [12:0] a);
		logic [12:0] v;
		v = a;
		for (int k = 0; k < 5; k++) begin
			if (v >= 13'(MEMORY_BYTES))
				v = v - 13'(MEMORY_BYTES);
		end
		return v[AW-1:0];
	endfunction

	// shared alu
	c8i_pkg::alu_op_t alu_op;
	logic [11:0] alu_a;
	logic [11:0] alu_b;
	logic [12:0] alu_y;

	c8i_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	always_comb begin
		alu_op = c8i_pkg::ALU_ADD;
		alu_a  = pc_q;
		alu_b  = 12'd2;
		unique case (state_q)
			S_FETCH_LO: begin
				alu_b = 12'd1;
			end
			S_EXEC: begin
				unique case (op_hi)
					4'h3, 4'h4: begin
						alu_op = c8i_pkg::ALU_SUB;
						alu_a  = {4'b0, vx_q};
						alu_b  = {4'b0, op_nn};
					end
					4'h5, 4'h9: begin
						alu_op = c8i_pkg::ALU_SUB;
						alu_a  = {4'b0, vx_q};
						alu_b  = {4'b0, vy_q};
					end
					4'h7: begin
						alu_a = {4'b0, vx_q};
						alu_b = {4'b0, op_nn};
					end
					4'h8: begin
						alu_a = {4'b0, vx_q};
						alu_b = {4'b0, vy_q};
						unique case (op_n)
							4'h0: alu_op = c8i_pkg::ALU_PASS;
							4'h1: alu_op = c8i_pkg::ALU_OR;
							4'h2: alu_op = c8i_pkg::ALU_AND;
							4'h3: alu_op = c8i_pkg::ALU_XOR;
							4'h5: alu_op = c8i_pkg::ALU_SUB;
							4'h6: alu_op = c8i_pkg::ALU_SHR;
							4'h7: begin
								alu_op = c8i_pkg::ALU_SUB;
								alu_a  = {4'b0, vy_q};
								alu_b  = {4'b0, vx_q};
							end
							4'hE: alu_op = c8i_pkg::ALU_SHL;
							default: alu_op = c8i_pkg::ALU_ADD;
						endcase
					end
					4'hB: begin
						alu_a = op_nnn;
						alu_b = {4'b0, vy_q};
					end
					4'hF: begin
						alu_a = i_q;
						alu_b = {4'b0, vx_q};
					end
					default: ;
				endcase
			end
			S_ADVANCE: begin
				alu_b = {9'b0, step_q};
			end
			S_DRAW_RD, S_BCD, S_STORE, S_LOAD_RD: begin
				alu_a = i_q;
				alu_b = {8'b0, cnt_q};
			end
			S_DRAW_XOR: begin
				alu_a = {4'b0, vy_q};
				alu_b = {8'b0, cnt_q};
			end
			default: ;
		endcase
	end

	// register file read, one address a cycle
	logic [3:0] rf_sel;
	logic [7:0] rf_rd;

	always_comb begin
		unique case (state_q)
			S_READ_X: rf_sel = op_x;
			S_READ_Y: rf_sel = (op_hi == 4'hB) ? 4'h0 : op_y;
			default:  rf_sel = cnt_q;
		endcase
	end

	assign rf_rd = v_q[rf_sel];

	// display read, one row a cycle
	logic [4:0]  disp_sel;
	logic [63:0] disp_rd;

	assign disp_sel = (state_q == S_DONE) ? row_sel_q : alu_y[4:0];
	assign disp_rd  = disp_q[disp_sel];

	// program memory
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic [AW:0]   font_off;
	logic [7:0]    clr_data;

	assign font_off = {1'b0, clr_addr_q} - (AW+1)'(c8i_pkg::FONT_BASE);
	assign clr_data = (font_off < (AW+1)'(c8i_pkg::FONT_BYTES)) ?
		c8i_pkg::glyph(font_off[6:0]) : 8'h00;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = mem_addr(alu_y);
		mem_wdata = rf_rd;
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = clr_data;
		end else if (state_q == S_MISC && mode_q == c8i_pkg::MODE_LOAD) begin
			mem_we    = 1'b1;
			mem_waddr = mem_addr({1'b0, laddr_q});
			mem_wdata = ldata_q;
		end else if (state_q == S_BCD) begin
			mem_we    = 1'b1;
			mem_wdata = {4'b0, c8i_pkg::bcd_digit(vx_q, cnt_q[1:0])};
		end else if (state_q == S_STORE) begin
			mem_we    = 1'b1;
		end
	end

	assign mem_raddr = (state_q == S_FETCH_HI) ? mem_addr({1'b0, pc_q}) : mem_addr(alu_y);

	c8i_ram #(
		.DEPTH (MEMORY_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sprite byte placed at column vx with wraparound
	logic [127:0] spr_dbl;
	logic [63:0]  spr_mask;

	assign spr_dbl  = {mem_rdata, 56'b0, mem_rdata, 56'b0} >> vx_q[5:0];
	assign spr_mask = spr_dbl[63:0];

	// lowest pressed key
	logic [3:0] key_first;

	always_comb begin
		key_first = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k])
				key_first = 4'(k);
		end
	end

	logic key_hit;
	assign key_hit = keys_q[vx_q[3:0]];

	logic [SW-1:0] sp_inc;
	logic [SW-1:0] sp_dec;
	assign sp_inc = (sp_q == SW'(STACK_DEPTH-1)) ? '0 : sp_q + SW'(1);
	assign sp_dec = (sp_q == '0) ? SW'(STACK_DEPTH-1) : sp_q - SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= 12'(c8i_pkg::PROGRAM_BASE);
			i_q         <= '0;
			v_q         <= '{default: '0};
			stack_q     <= '{default: '0};
			sp_q        <= '0;
			delay_q     <= '0;
			sound_q     <= '0;
			disp_q      <= '{default: '0};
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(MEMORY_BYTES-1))
					clr_busy_q <= 1'b0;
			end
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid && !clr_busy_q) begin
						mode_q    <= cmd.data.mode;
						keys_q    <= cmd.data.key_mask;
						rnd_q     <= cmd.data.random_byte;
						laddr_q   <= cmd.data.load_address;
						ldata_q   <= cmd.data.load_data;
						row_sel_q <= cmd.data.row_select;
						drew_q    <= 1'b0;
						unk_q     <= 1'b0;
						wait_q    <= 1'b0;
						state_q   <= (cmd.data.mode == c8i_pkg::MODE_EXEC) ? S_FETCH_HI : S_MISC;
					end
				end
				S_MISC: begin
					if (mode_q == c8i_pkg::MODE_TICK) begin
						if (delay_q != 8'd0)
							delay_q <= delay_q - 8'd1;
						if (sound_q != 8'd0)
							sound_q <= sound_q - 8'd1;
					end
					state_q <= S_DONE;
				end
				S_FETCH_HI: state_q <= S_FETCH_LO;
				S_FETCH_LO: begin
					op_q[15:8] <= mem_rdata;
					state_q    <= S_OPCODE;
				end
				S_OPCODE: begin
					op_q[7:0] <= mem_rdata;
					state_q   <= S_READ_X;
				end
				S_READ_X: begin
					vx_q    <= rf_rd;
					state_q <= S_READ_Y;
				end
				S_READ_Y: begin
					vy_q    <= rf_rd;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					step_q  <= 3'd2;
					cnt_q   <= 4'd0;
					state_q <= S_ADVANCE;
					unique case (op_hi)
						4'h0: begin
							if (op_q == 16'h00E0) begin
								disp_q <= '{default: '0};
								drew_q <= 1'b1;
							end else if (op_q == 16'h00EE) begin
								sp_q    <= sp_dec;
								state_q <= S_RET;
							end else begin
								unk_q <= 1'b1;
							end
						end
						4'h1: begin
							pc_q    <= op_nnn;
							state_q <= S_DONE;
						end
						4'h2: begin
							stack_q[sp_q] <= pc_q;
							sp_q          <= sp_inc;
							pc_q          <= op_nnn;
							state_q       <= S_DONE;
						end
						4'h3: step_q <= (alu_y == 13'd0) ? 3'd4 : 3'd2;
						4'h4: step_q <= (alu_y != 13'd0) ? 3'd4 : 3'd2;
						4'h5, 4'h9: begin
							if (op_n != 4'h0)
								unk_q <= 1'b1;
							else if ((alu_y == 13'd0) == (op_hi == 4'h5))
								step_q <= 3'd4;
						end
						4'h6: v_q[op_x] <= op_nn;
						4'h7: v_q[op_x] <= alu_y[7:0];
						4'h8: begin
							unique case (op_n)
								4'h0, 4'h1, 4'h2, 4'h3: v_q[op_x] <= alu_y[7:0];
								4'h4: begin
									v_q[op_x] <= alu_y[7:0];
									v_q[15]   <= {7'b0, alu_y[8]};
								end
								4'h5, 4'h7: begin
									v_q[op_x] <= alu_y[7:0];
									v_q[15]   <= {7'b0, ~alu_y[12]};
								end
								4'h6: begin
									v_q[op_x] <= alu_y[7:0];
									v_q[15]   <= {7'b0, vx_q[0]};
								end
								4'hE: begin
									v_q[op_x] <= alu_y[7:0];
									v_q[15]   <= {7'b0, vx_q[7]};
								end
								default: unk_q <= 1'b1;
							endcase
						end
						4'hA: i_q <= op_nnn;
						4'hB: begin
							pc_q    <= alu_y[11:0];
							state_q <= S_DONE;
						end
						4'hC: v_q[op_x] <= rnd_q & op_nn;
						4'hD: begin
							coll_q  <= 1'b0;
							drew_q  <= 1'b1;
							state_q <= (op_n == 4'h0) ? S_DRAW_END : S_DRAW_RD;
						end
						4'hE: begin
							if (op_nn == 8'h9E)
								step_q <= key_hit ? 3'd4 : 3'd2;
							else if (op_nn == 8'hA1)
								step_q <= key_hit ? 3'd2 : 3'd4;
							else
								unk_q <= 1'b1;
						end
						4'hF: begin
							unique case (op_nn)
								8'h07: v_q[op_x] <= delay_q;
								8'h0A: begin
									if (keys_q != 16'h0000) begin
										v_q[op_x] <= {4'b0, key_first};
									end else begin
										wait_q  <= 1'b1;
										state_q <= S_DONE;
									end
								end
								8'h15: delay_q <= vx_q;
								8'h18: sound_q <= vx_q;
								8'h1E: begin
									i_q     <= alu_y[11:0];
									v_q[15] <= {7'b0, alu_y[12]};
								end
								8'h29: i_q <= 12'(c8i_pkg::FONT_BASE) +
									{6'b0, vx_q[3:0], 2'b0} + {8'b0, vx_q[3:0]};
								8'h33: state_q <= S_BCD;
								8'h55: state_q <= S_STORE;
								8'h65: state_q <= S_LOAD_RD;
								default: unk_q <= 1'b1;
							endcase
						end
						default: unk_q <= 1'b1;
					endcase
				end
				S_RET: begin
					pc_q    <= stack_q[sp_q];
					state_q <= S_ADVANCE;
				end
				S_DRAW_RD: state_q <= S_DRAW_XOR;
				S_DRAW_XOR: begin
					// row index comes from vy + row count on the alu
					if ((disp_rd & spr_mask) != 64'd0)
						coll_q <= 1'b1;
					disp_q[disp_sel] <= disp_rd ^ spr_mask;
					cnt_q            <= cnt_q + 4'd1;
					state_q <= ((cnt_q + 4'd1) == op_n) ? S_DRAW_END : S_DRAW_RD;
				end
				S_DRAW_END: begin
					v_q[15] <= {7'b0, coll_q};
					state_q <= S_ADVANCE;
				end
				S_BCD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd2)
						state_q <= S_ADVANCE;
				end
				S_STORE: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == op_x)
						state_q <= S_ADVANCE;
				end
				S_LOAD_RD: state_q <= S_LOAD_WR;
				S_LOAD_WR: begin
					v_q[cnt_q] <= mem_rdata;
					cnt_q      <= cnt_q + 4'd1;
					state_q    <= (cnt_q == op_x) ? S_ADVANCE : S_LOAD_RD;
				end
				S_ADVANCE: begin
					pc_q    <= alu_y[11:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q                <= 1'b1;
						rsp_data_q.program_counter <= pc_q;
						rsp_data_q.fetched_opcode  <= (mode_q == c8i_pkg::MODE_EXEC) ? op_q : 16'h0;
						rsp_data_q.draw_flag       <= drew_q;
						rsp_data_q.unknown_opcode  <= unk_q;
						rsp_data_q.waiting_key     <= wait_q;
						rsp_data_q.sound_on        <= (sound_q != 8'd0);
						rsp_data_q.row_pixels      <= (mode_q == c8i_pkg::MODE_READ) ? disp_rd : 64'd0;
						state_q                    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready = (state_q == S_IDLE) && !clr_busy_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	`C8I_ASSERT_IMP(a_no_accept_in_clear, cmd.valid && cmd.ready, !clr_busy_q, "item accepted during memory clear")
	`C8I_ASSERT_NXT(a_accept_starts_work, cmd.valid && cmd.ready, state_q != S_IDLE, "accepted item did not start")
	`C8I_ASSERT_IMP(a_sp_in_range, 1'b1, sp_q <= SW'(STACK_DEPTH-1), "stack index out of range")
	`C8I_ASSERT_NXT(a_done_holds, state_q == S_DONE && rsp_valid_q && !rsp.ready, state_q == S_DONE, "result slot overwritten")

endmodule

`default_nettype wire

/* sim/chip8_interpreter_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_interpreter_core_checker
// watches the cmd and rsp channels, runs its own model of the machine on
// every accepted cmd word and compares each rsp word with the oldest outcome
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_interpreter_core_checker
	import c8i_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	c8i_stream_if       cmd,
	c8i_stream_if       rsp,
	output int          errors,
	output int          pending,
	output logic [11:0] pc_now
);

	logic [7:0]  mem [4096];
	logic [63:0] screen [32];
	logic [7:0]  v [16];
	logic [11:0] idx;
	logic [11:0] pc;
	logic [11:0] stack [16];
	logic [3:0]  sp;
	logic [7:0]  delay_cnt;
	logic [7:0]  sound_cnt;

	rsp_word_t outcomes [$];

	task automatic machine_reset();
		for (int a = 0; a < 4096; a++)
			mem[a] = 8'h00;
		for (int a = 0; a < FONT_BYTES; a++)
			mem[(FONT_BASE + a) % 4096] = GLYPHS[a];
		for (int a = 0; a < 32; a++)
			screen[a] = '0;
		for (int a = 0; a < 16; a++) begin
			v[a] = '0;
			stack[a] = '0;
		end
		idx = '0;
		pc = 12'(PROGRAM_BASE);
		sp = '0;
		delay_cnt = '0;
		sound_cnt = '0;
	endtask

	task automatic run_word(input cmd_word_t c, output rsp_word_t r);
		logic [15:0] op;
		logic [3:0]  x, y, n;
		logic [7:0]  nn, vx, vy, res, bits;
		logic [11:0] nnn;
		logic [12:0] wide;
		logic        flag, has_flag;
		logic [4:0]  row;
		logic [5:0]  col;
		int          k;
		r = '0;
		op = '0;
		case (c.mode)
			MODE_EXEC: begin
				op = {mem[pc], mem[pc + 12'd1]};
				x = op[11:8];
				y = op[7:4];
				n = op[3:0];
				nn = op[7:0];
				nnn = op[11:0];
				vx = v[x];
				vy = v[y];
				case (op[15:12])
					4'h0: begin
						if (op == 16'h00E0) begin
							for (int a = 0; a < 32; a++)
								screen[a] = '0;
							r.draw_flag = 1'b1;
						end else if (op == 16'h00EE) begin
							sp = sp - 4'd1;
							pc = stack[sp];
						end else
							r.unknown_opcode = 1'b1;
						pc = pc + 12'd2;
					end
					4'h1: pc = nnn;
					4'h2: begin
						stack[sp] = pc;
						sp = sp + 4'd1;
						pc = nnn;
					end
					4'h3: pc = pc + ((vx == nn) ? 12'd4 : 12'd2);
					4'h4: pc = pc + ((vx != nn) ? 12'd4 : 12'd2);
					4'h5, 4'h9: begin
						if (n != 4'h0) begin
							r.unknown_opcode = 1'b1;
							pc = pc + 12'd2;
						end else
							pc = pc + (((vx == vy) == (op[15:12] == 4'h5)) ? 12'd4 : 12'd2);
					end
					4'h6: begin
						v[x] = nn;
						pc = pc + 12'd2;
					end
					4'h7: begin
						v[x] = vx + nn;
						pc = pc + 12'd2;
					end
					4'h8: begin
						has_flag = 1'b1;
						flag = 1'b0;
						res = '0;
						case (n)
							4'h0: begin res = vy; has_flag = 1'b0; end
							4'h1: begin res = vx | vy; has_flag = 1'b0; end
							4'h2: begin res = vx & vy; has_flag = 1'b0; end
							4'h3: begin res = vx ^ vy; has_flag = 1'b0; end
							4'h4: {flag, res} = {1'b0, vx} + {1'b0, vy};
							4'h5: begin res = vx - vy; flag = vx >= vy; end
							4'h6: begin res = vx >> 1; flag = vx[0]; end
							4'h7: begin res = vy - vx; flag = vy >= vx; end
							4'hE: begin res = vx << 1; flag = vx[7]; end
							default: r.unknown_opcode = 1'b1;
						endcase
						if (!r.unknown_opcode) begin
							v[x] = res;
							if (has_flag)
								v[15] = {7'd0, flag};
						end
						pc = pc + 12'd2;
					end
					4'hA: begin
						idx = nnn;
						pc = pc + 12'd2;
					end
					4'hB: pc = nnn + {4'd0, v[0]};
					4'hC: begin
						v[x] = c.random_byte & nn;
						pc = pc + 12'd2;
					end
					4'hD: begin
						flag = 1'b0;
						for (int i = 0; i < n; i++) begin
							bits = mem[idx + 12'(i)];
							row = vy[4:0] + 5'(i);
							for (int b = 0; b < 8; b++) begin
								if (bits[7 - b]) begin
									col = vx[5:0] + 6'(b);
									if (screen[row][63 - col])
										flag = 1'b1;
									screen[row][63 - col] = ~screen[row][63 - col];
								end
							end
						end
						v[15] = {7'd0, flag};
						r.draw_flag = 1'b1;
						pc = pc + 12'd2;
					end
					4'hE: begin
						if (nn == 8'h9E)
							pc = pc + (c.key_mask[vx[3:0]] ? 12'd4 : 12'd2);
						else if (nn == 8'hA1)
							pc = pc + (c.key_mask[vx[3:0]] ? 12'd2 : 12'd4);
						else begin
							r.unknown_opcode = 1'b1;
							pc = pc + 12'd2;
						end
					end
					default: begin
						case (nn)
							8'h07: v[x] = delay_cnt;
							8'h0A: begin
								k = 16;
								for (int i = 15; i >= 0; i--)
									if (c.key_mask[i])
										k = i;
								if (k < 16)
									v[x] = 8'(k);
								else
									r.waiting_key = 1'b1;
							end
							8'h15: delay_cnt = vx;
							8'h18: sound_cnt = vx;
							8'h1E: begin
								wide = {1'b0, idx} + {5'd0, vx};
								idx = wide[11:0];
								v[15] = {7'd0, wide[12]};
							end
							8'h29: idx = 12'(FONT_BASE + 5 * vx[3:0]);
							8'h33: begin
								mem[idx] = vx / 8'd100;
								mem[idx + 12'd1] = (vx % 8'd100) / 8'd10;
								mem[idx + 12'd2] = vx % 8'd10;
							end
							8'h55: for (int i = 0; i <= x; i++)
								mem[idx + 12'(i)] = v[i];
							8'h65: for (int i = 0; i <= x; i++)
								v[i] = mem[idx + 12'(i)];
							default: r.unknown_opcode = 1'b1;
						endcase
						if (!r.waiting_key)
							pc = pc + 12'd2;
					end
				endcase
			end
			MODE_TICK: begin
				if (delay_cnt != 0)
					delay_cnt = delay_cnt - 8'd1;
				if (sound_cnt != 0)
					sound_cnt = sound_cnt - 8'd1;
			end
			MODE_LOAD: mem[c.load_address] = c.load_data;
			default: r.row_pixels = screen[c.row_select];
		endcase
		r.program_counter = pc;
		r.fetched_opcode = op;
		r.sound_on = sound_cnt != 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t e, got;
		if (!arst_n) begin
			machine_reset();
			outcomes.delete();
			errors <= 0;
			pending <= 0;
			pc_now <= 12'(PROGRAM_BASE);
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (outcomes.size() == 0) begin
					$error("rsp word with no outcome waiting");
					errors <= errors + 1;
				end else begin
					e = outcomes.pop_front();
					if (got !== e) begin
						errors <= errors + 1;
						if (got.program_counter !== e.program_counter)
							$error("program_counter exp %h got %h", e.program_counter,
								got.program_counter);
						if (got.fetched_opcode !== e.fetched_opcode)
							$error("fetched_opcode exp %h got %h", e.fetched_opcode,
								got.fetched_opcode);
						if (got.draw_flag !== e.draw_flag)
							$error("draw_flag exp %b got %b", e.draw_flag, got.draw_flag);
						if (got.unknown_opcode !== e.unknown_opcode)
							$error("unknown_opcode exp %b got %b", e.unknown_opcode,
								got.unknown_opcode);
						if (got.waiting_key !== e.waiting_key)
							$error("waiting_key exp %b got %b", e.waiting_key, got.waiting_key);
						if (got.sound_on !== e.sound_on)
							$error("sound_on exp %b got %b", e.sound_on, got.sound_on);
						if (got.row_pixels !== e.row_pixels)
							$error("row_pixels exp %h got %h", e.row_pixels, got.row_pixels);
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				run_word(cmd.data, e);
				outcomes.push_back(e);
			end
			pending <= outcomes.size();
			pc_now <= pc;
		end
	end

endmodule

`default_nettype wire

/* sim/chip8_interpreter_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_interpreter_core_test
// drives directed and random cmd words into the interpreter core: most
// execute words run opcodes that were first written at the current pc
// ----------------------------------------------------------------------------
`default_nettype none

module chip8_interpreter_core_test;
	import c8i_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	int          errors;
	int          pending;
	logic [11:0] pc_now;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          stall_cnt;

	c8i_stream_if #(.word_t(cmd_word_t)) cmd_ch ();
	c8i_stream_if #(.word_t(rsp_word_t)) rsp_ch ();

	chip8_interpreter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	chip8_interpreter_core_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.errors(errors),
		.pending(pending),
		.pc_now(pc_now)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= $urandom_range(99) >= rx_idle_pct;
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("[chip8_interpreter_core] ERROR");
			$finish;
		end
	end

	// called at a rising edge; leaves valid high after the word is taken
	task automatic send(input cmd_word_t w);
		int gap;
		gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.data <= w;
		cmd_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	function automatic cmd_word_t noise_word();
		cmd_word_t w;
		w = cmd_word_t'({$urandom, $urandom});
		return w;
	endfunction

	task automatic send_mode(input logic [1:0] m, input logic [11:0] a, input logic [7:0] d,
		input logic [4:0] r);
		cmd_word_t w;
		w = noise_word();
		w.mode = m;
		w.load_address = a;
		w.load_data = d;
		w.row_select = r;
		send(w);
	endtask

	// write op at the current pc, then execute it
	task automatic run_op(input logic [15:0] op, input logic [15:0] keys,
		input logic [7:0] rnd);
		cmd_word_t w;
		logic [11:0] at;
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		at = pc_now;
		@(posedge clk);
		send_mode(MODE_LOAD, at, op[15:8], 5'd0);
		send_mode(MODE_LOAD, at + 12'd1, op[7:0], 5'd0);
		w = noise_word();
		w.mode = MODE_EXEC;
		w.key_mask = keys;
		w.random_byte = rnd;
		send(w);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] random_op();
		logic [15:0] op;
		logic [3:0]  sel;
		op = 16'($urandom);
		sel = op[15:12];
		case (sel)
			4'h0: case ($urandom_range(3))
				0: op = 16'h00E0;
				1, 2: op = 16'h00EE;
				default: ;
			endcase
			4'h5, 4'h9: if ($urandom_range(3) != 0) op[3:0] = 4'h0;
			4'h8: if ($urandom_range(7) != 0) begin
				op[3:0] = 4'($urandom_range(8));
				if (op[3:0] == 4'h8)
					op[3:0] = 4'hE;
			end
			4'hD: op[3:0] = 4'($urandom_range(6));
			4'hE: if ($urandom_range(5) != 0) op[7:0] = $urandom_range(1) ? 8'h9E : 8'hA1;
			4'hF: case ($urandom_range(9))
				0: op[7:0] = 8'h07;
				1: op[7:0] = 8'h0A;
				2: op[7:0] = 8'h15;
				3: op[7:0] = 8'h18;
				4: op[7:0] = 8'h1E;
				5: op[7:0] = 8'h29;
				6: op[7:0] = 8'h33;
				7: op[7:0] = 8'h55;
				8: op[7:0] = 8'h65;
				default: ;
			endcase
			default: ;
		endcase
		return op;
	endfunction

	initial begin
		logic [15:0] keys;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		rsp_ch.ready = 1'b0;
		stall_cnt = 0;
		tx_idle_pct = 37;
		rx_idle_pct = 73;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, wrapped sprites, flag writes, key wait
		send_mode(MODE_READ, 12'h000, 8'h00, 5'd0);
		send_mode(MODE_LOAD, 12'hFFF, 8'hFF, 5'd31);
		run_op(16'h6A3E, 16'h0000, 8'h00);
		run_op(16'h6B1E, 16'h0000, 8'h00);
		run_op(16'h6C08, 16'h0000, 8'h00);
		run_op(16'hFC29, 16'h0000, 8'h00);
		run_op(16'hDAB5, 16'h0000, 8'h00);
		run_op(16'hDAB5, 16'h0000, 8'h00);
		send_mode(MODE_READ, 12'h000, 8'h00, 5'd31);
		run_op(16'hD000, 16'h0000, 8'h00);
		run_op(16'h6FFF, 16'h0000, 8'h00);
		run_op(16'h8FF4, 16'h0000, 8'h00);
		run_op(16'hF10A, 16'h0000, 8'h00);
		run_op(16'hF10A, 16'h8000, 8'h00);
		run_op(16'hC1AA, 16'hFFFF, 8'hFF);
		run_op(16'hAFFF, 16'h0000, 8'h00);
		run_op(16'hF11E, 16'h0000, 8'h00);
		run_op(16'hF133, 16'h0000, 8'h00);
		run_op(16'hFE55, 16'h0000, 8'h00);
		run_op(16'h2FFE, 16'h0000, 8'h00);
		run_op(16'h00EE, 16'h0000, 8'h00);
		run_op(16'h0123, 16'h0000, 8'h00);
		run_op(16'h5121, 16'h0000, 8'h00);
		run_op(16'h800F, 16'h0000, 8'h00);
		run_op(16'hF118, 16'h0000, 8'h00);
		send_mode(MODE_TICK, 12'h000, 8'h00, 5'd0);
		run_op(16'h00E0, 16'h0000, 8'h00);
		drain();

		for (int k = 0; k < 260; k++) begin
			if (k == 90) begin
				tx_idle_pct = 73;
				rx_idle_pct = 37;
				drain();
			end else if (k == 180) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (k == 130)
				drain();
			case ($urandom_range(9))
				0: send(noise_word());
				1: send_mode(MODE_READ, 12'h000, 8'h00, 5'($urandom));
				2: send_mode(MODE_TICK, 12'h000, 8'h00, 5'd0);
				default: begin
					keys = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
					run_op(random_op(), keys, 8'($urandom));
				end
			endcase
		end

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("[chip8_interpreter_core] OK");
		else
			$display("[chip8_interpreter_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
